// ===== rtl/bse_pkg.sv =====
// ============================================================================
// Button settings editor package
// Shared types, codes and constants for the button settings editor.
// ============================================================================
package bse_pkg;

    // Field widths.
    localparam int TIME_W   = 32;
    localparam int BTN_W    = 5;
    localparam int FIELD_W  = 3;
    localparam int HOUR_W   = 5;
    localparam int MS_W     = 6;
    localparam int COUNT_W  = 14;
    localparam int TOTAL_H_W = 14;
    localparam int HOLDOFF_W = 16;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_HOLDOFF    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LOW = 1'd1;

    // Reset values.
    localparam logic [HOLDOFF_W-1:0] HOLDOFF_RESET    = 16'd250;
    localparam logic                 ACTIVE_LOW_RESET = 1'b1;
    localparam logic                 SAVING_RESET     = 1'b1;
    localparam logic [MS_W-1:0]      LAPSE_SEC_RESET  = 6'd30;
    localparam logic [COUNT_W-1:0]   COUNT_RESET      = 14'd200;

    // Limits.
    localparam logic [HOUR_W-1:0]  HOUR_MAX    = 5'd24;
    localparam logic [MS_W-1:0]    MS_MAX      = 6'd59;
    localparam logic [COUNT_W:0]   COUNT_MAX   = 15'd9999;

    // Constant division by 3600 and by 60 through reciprocal multiplies.
    // The hour quotient may come out one low and is corrected afterwards;
    // the minute quotient is exact for every remainder below 3600.
    localparam logic [14:0] HOUR_RECIP  = 15'd18641;
    localparam int          HOUR_SHIFT  = 26;
    localparam logic [12:0] MIN_RECIP   = 13'd4370;
    localparam int          MIN_SHIFT   = 18;
    localparam logic [11:0] SECS_PER_HOUR = 12'd3600;

    // Decoded button patterns after polarity.
    localparam logic [BTN_W-1:0] PAT_SEL_UP   = 5'd1;
    localparam logic [BTN_W-1:0] PAT_SEL_DOWN = 5'd2;
    localparam logic [BTN_W-1:0] PAT_SEL_BOTH = 5'd3;
    localparam logic [BTN_W-1:0] PAT_UP       = 5'd4;
    localparam logic [BTN_W-1:0] PAT_DOWN     = 5'd8;
    localparam logic [BTN_W-1:0] PAT_SHOOT    = 5'd16;

    // Edit field codes.
    localparam logic [FIELD_W-1:0] FIELD_DELAY_HOUR = 3'd0;
    localparam logic [FIELD_W-1:0] FIELD_DELAY_MIN  = 3'd1;
    localparam logic [FIELD_W-1:0] FIELD_LAPSE_MIN  = 3'd2;
    localparam logic [FIELD_W-1:0] FIELD_LAPSE_SEC  = 3'd3;
    localparam logic [FIELD_W-1:0] FIELD_DIGIT_K    = 3'd4;
    localparam logic [FIELD_W-1:0] FIELD_DIGIT_H    = 3'd5;
    localparam logic [FIELD_W-1:0] FIELD_DIGIT_T    = 3'd6;
    localparam logic [FIELD_W-1:0] FIELD_DIGIT_U    = 3'd7;

    // Settings snapshot carried with each beat.
    typedef struct packed {
        logic               updated;
        logic [FIELD_W-1:0] field_sel;
        logic               saving_on;
        logic               shooting_on;
        logic [HOUR_W-1:0]  delay_hours;
        logic [MS_W-1:0]    delay_minutes;
        logic [MS_W-1:0]    lapse_minutes;
        logic [MS_W-1:0]    lapse_seconds;
        logic [COUNT_W-1:0] shot_count;
    } settings_t;

    // Total duration split into hours, minutes and seconds.
    typedef struct packed {
        logic [TOTAL_H_W-1:0] hours;
        logic [MS_W-1:0]      minutes;
        logic [MS_W-1:0]      seconds;
    } total_t;

    // Weight of the count digit chosen by a digit field.
    function automatic logic [COUNT_W:0] digit_weight(input logic [FIELD_W-1:0] field);
        logic [COUNT_W:0] w;
        case (field)
            FIELD_DIGIT_K: w = 15'd1000;
            FIELD_DIGIT_H: w = 15'd100;
            FIELD_DIGIT_T: w = 15'd10;
            default:       w = 15'd1;
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/bse_if.sv =====
// ============================================================================
// Button settings editor channels
// Valid/ready channels for button samples and settings results.
// ============================================================================
interface bse_sample_if;
    logic                        valid;
    logic                        ready;
    logic [bse_pkg::TIME_W-1:0]  time_ms;
    logic [bse_pkg::BTN_W-1:0]   raw_buttons;

    modport source (output valid, output time_ms, output raw_buttons, input ready);
    modport sink   (input valid, input time_ms, input raw_buttons, output ready);
endinterface

interface bse_result_if;
    logic                          valid;
    logic                          ready;
    logic                          updated;
    logic [bse_pkg::FIELD_W-1:0]   field_sel;
    logic                          saving_on;
    logic                          shooting_on;
    logic [bse_pkg::HOUR_W-1:0]    delay_hours;
    logic [bse_pkg::MS_W-1:0]      delay_minutes;
    logic [bse_pkg::MS_W-1:0]      lapse_minutes;
    logic [bse_pkg::MS_W-1:0]      lapse_seconds;
    logic [bse_pkg::COUNT_W-1:0]   shot_count;
    logic [bse_pkg::TOTAL_H_W-1:0] total_hours;
    logic [bse_pkg::MS_W-1:0]      total_minutes;
    logic [bse_pkg::MS_W-1:0]      total_seconds;

    modport source (
        output valid, output updated, output field_sel, output saving_on,
        output shooting_on, output delay_hours, output delay_minutes,
        output lapse_minutes, output lapse_seconds, output shot_count,
        output total_hours, output total_minutes, output total_seconds,
        input ready
    );
    modport sink (
        input valid, input updated, input field_sel, input saving_on,
        input shooting_on, input delay_hours, input delay_minutes,
        input lapse_minutes, input lapse_seconds, input shot_count,
        input total_hours, input total_minutes, input total_seconds,
        output ready
    );
endinterface

// ===== rtl/bse_edit.sv =====
// ============================================================================
// Button settings edit stage
// Registers a sample, applies hold-off and pattern decode, updates settings.
// ============================================================================
module bse_edit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [bse_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bse_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [bse_pkg::TIME_W-1:0]        in_time,
    input  logic [bse_pkg::BTN_W-1:0]         in_raw,
    output logic                              out_valid,
    input  logic                              out_ready,
    output bse_pkg::settings_t                out_settings
);

    logic [bse_pkg::HOLDOFF_W-1:0] holdoff_reg;
    logic                          active_low_reg;

    logic                          a_valid_reg;
    logic [bse_pkg::TIME_W-1:0]    a_time_reg;
    logic [bse_pkg::BTN_W-1:0]     a_raw_reg;

    logic                          b_valid_reg;
    bse_pkg::settings_t            b_settings_reg;

    logic [bse_pkg::TIME_W-1:0]    last_window_reg, last_window_next;
    logic [bse_pkg::FIELD_W-1:0]   field_reg, field_next;
    logic                          saving_reg, saving_next;
    logic                          shooting_reg, shooting_next;
    logic [bse_pkg::HOUR_W-1:0]    dhour_reg, dhour_next;
    logic [bse_pkg::MS_W-1:0]      dmin_reg, dmin_next;
    logic [bse_pkg::MS_W-1:0]      lmin_reg, lmin_next;
    logic [bse_pkg::MS_W-1:0]      lsec_reg, lsec_next;
    logic [bse_pkg::COUNT_W-1:0]   count_reg, count_next;

    logic                          b_free;
    logic                          advance;
    logic [bse_pkg::TIME_W-1:0]    elapsed;
    logic                          window_open;
    logic [bse_pkg::BTN_W-1:0]     pat;
    logic                          upd;
    logic                          edit_up;
    logic                          edit_down;
    logic [bse_pkg::COUNT_W:0]     weight;
    logic [bse_pkg::COUNT_W:0]     nine_w;
    logic [bse_pkg::COUNT_W:0]     cnt;
    logic [bse_pkg::COUNT_W:0]     cnt_edit;
    logic [bse_pkg::MS_W-1:0]      sel_ms;
    logic [bse_pkg::MS_W-1:0]      sel_ms_edit;

    assign b_free   = !b_valid_reg || out_ready;
    assign advance  = a_valid_reg && b_free;
    assign in_ready = !a_valid_reg || b_free;

    assign out_valid    = b_valid_reg;
    assign out_settings = b_settings_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            holdoff_reg    <= bse_pkg::HOLDOFF_RESET;
            active_low_reg <= bse_pkg::ACTIVE_LOW_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bse_pkg::CFG_HOLDOFF:    holdoff_reg    <= cfg_data[bse_pkg::HOLDOFF_W-1:0];
                bse_pkg::CFG_ACTIVE_LOW: active_low_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Edit logic on the registered sample.
    always_comb
    begin
        elapsed     = a_time_reg - last_window_reg;
        window_open = elapsed > {{(bse_pkg::TIME_W-bse_pkg::HOLDOFF_W){1'b0}}, holdoff_reg};
        pat         = active_low_reg ? ~a_raw_reg : a_raw_reg;

        last_window_next = last_window_reg;
        field_next       = field_reg;
        saving_next      = saving_reg;
        shooting_next    = shooting_reg;
        dhour_next       = dhour_reg;
        dmin_next        = dmin_reg;
        lmin_next        = lmin_reg;
        lsec_next        = lsec_reg;
        count_next       = count_reg;
        upd              = 1'b0;
        edit_up          = 1'b0;
        edit_down        = 1'b0;

        if (window_open)
        begin
            last_window_next = a_time_reg;
            upd              = 1'b1;
            case (pat)
                bse_pkg::PAT_SEL_UP:   field_next    = field_reg + 1'b1;
                bse_pkg::PAT_SEL_DOWN: field_next    = field_reg - 1'b1;
                bse_pkg::PAT_SEL_BOTH: saving_next   = !saving_reg;
                bse_pkg::PAT_UP:       edit_up       = 1'b1;
                bse_pkg::PAT_DOWN:     edit_down     = 1'b1;
                bse_pkg::PAT_SHOOT:    shooting_next = !shooting_reg;
                default:               upd           = 1'b0;
            endcase
        end

        // Minute/second field with wrap at sixty.
        case (field_reg)
            bse_pkg::FIELD_DELAY_MIN: sel_ms = dmin_reg;
            bse_pkg::FIELD_LAPSE_MIN: sel_ms = lmin_reg;
            default:                  sel_ms = lsec_reg;
        endcase
        if (edit_up)
            sel_ms_edit = (sel_ms >= bse_pkg::MS_MAX) ? '0 : sel_ms + 1'b1;
        else
            sel_ms_edit = (sel_ms == '0) ? bse_pkg::MS_MAX : sel_ms - 1'b1;

        // Count digit edit, then clamp to the four-digit range.
        weight = bse_pkg::digit_weight(field_reg);
        nine_w = (weight << 3) + weight;
        cnt    = {1'b0, count_reg};
        if (edit_down && cnt < weight)
            cnt_edit = cnt + nine_w;
        else if (edit_up && cnt >= nine_w && cnt < (nine_w + weight))
            cnt_edit = cnt - nine_w;
        else if (edit_up)
            cnt_edit = cnt + weight;
        else
            cnt_edit = cnt - weight;
        if (cnt_edit > bse_pkg::COUNT_MAX)
            cnt_edit = bse_pkg::COUNT_MAX;

        if (edit_up || edit_down)
        begin
            case (field_reg)
                bse_pkg::FIELD_DELAY_HOUR:
                begin
                    if (edit_up)
                        dhour_next = (dhour_reg >= bse_pkg::HOUR_MAX) ?
                                     bse_pkg::HOUR_MAX : dhour_reg + 1'b1;
                    else
                        dhour_next = (dhour_reg == '0) ? '0 : dhour_reg - 1'b1;
                end
                bse_pkg::FIELD_DELAY_MIN: dmin_next = sel_ms_edit;
                bse_pkg::FIELD_LAPSE_MIN: lmin_next = sel_ms_edit;
                bse_pkg::FIELD_LAPSE_SEC: lsec_next = sel_ms_edit;
                default:                  count_next = cnt_edit[bse_pkg::COUNT_W-1:0];
            endcase
        end
    end

    // Input register and settings state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg     <= 1'b0;
            b_valid_reg     <= 1'b0;
            last_window_reg <= '0;
            field_reg       <= '0;
            saving_reg      <= bse_pkg::SAVING_RESET;
            shooting_reg    <= 1'b0;
            dhour_reg       <= '0;
            dmin_reg        <= '0;
            lmin_reg        <= '0;
            lsec_reg        <= bse_pkg::LAPSE_SEC_RESET;
            count_reg       <= bse_pkg::COUNT_RESET;
        end
        else
        begin
            if (in_ready)
                a_valid_reg <= in_valid;
            if (b_free)
                b_valid_reg <= a_valid_reg;
            if (advance)
            begin
                last_window_reg <= last_window_next;
                field_reg       <= field_next;
                saving_reg      <= saving_next;
                shooting_reg    <= shooting_next;
                dhour_reg       <= dhour_next;
                dmin_reg        <= dmin_next;
                lmin_reg        <= lmin_next;
                lsec_reg        <= lsec_next;
                count_reg       <= count_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            a_time_reg <= in_time;
            a_raw_reg  <= in_raw;
        end
        if (advance)
        begin
            b_settings_reg.updated       <= upd;
            b_settings_reg.field_sel     <= field_next;
            b_settings_reg.saving_on     <= saving_next;
            b_settings_reg.shooting_on   <= shooting_next;
            b_settings_reg.delay_hours   <= dhour_next;
            b_settings_reg.delay_minutes <= dmin_next;
            b_settings_reg.lapse_minutes <= lmin_next;
            b_settings_reg.lapse_seconds <= lsec_next;
            b_settings_reg.shot_count    <= count_next;
        end
    end

endmodule

// ===== rtl/bse_duration.sv =====
// ============================================================================
// Button settings duration pipeline
// Computes the total shooting time and splits it into hours, minutes, seconds.
// ============================================================================
module bse_duration (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  bse_pkg::settings_t in_settings,
    output logic               out_valid,
    input  logic               out_ready,
    output bse_pkg::settings_t out_settings,
    output bse_pkg::total_t    out_total
);

    localparam int NSTAGE = 6;

    logic [NSTAGE-1:0] v_reg;
    logic [NSTAGE:0]   rdy;

    // Stage data: product, rough quotient, raw remainder, corrected split,
    // minutes, then the output register.
    bse_pkg::settings_t s_reg [NSTAGE];

    logic [25:0] prod1_reg;
    logic [25:0] prod2_reg;
    logic [13:0] q2_reg;
    logic [13:0] q3_reg;
    logic [12:0] rem3_reg;
    logic [13:0] h4_reg;
    logic [11:0] rem4_reg;
    logic [13:0] h5_reg;
    logic [11:0] rem5_reg;
    logic [5:0]  m5_reg;
    bse_pkg::total_t tot_reg;

    logic [11:0] base;
    logic [40:0] q_prod;
    logic [25:0] q_times;
    logic [25:0] rem_full;
    logic [24:0] m_prod;
    logic [11:0] m_times;
    logic [11:0] s_full;

    always_comb
    begin
        rdy[NSTAGE] = out_ready;
        for (int k = NSTAGE - 1; k >= 0; k--)
            rdy[k] = !v_reg[k] || rdy[k+1];
    end

    assign in_ready     = rdy[0];
    assign out_valid    = v_reg[NSTAGE-1];
    assign out_settings = s_reg[NSTAGE-1];
    assign out_total    = tot_reg;

    always_comb
    begin
        base     = ({6'd0, in_settings.lapse_minutes} << 6)
                 - ({6'd0, in_settings.lapse_minutes} << 2)
                 + {6'd0, in_settings.lapse_seconds};
        q_prod   = {15'd0, prod1_reg} * {26'd0, bse_pkg::HOUR_RECIP};
        q_times  = {12'd0, q2_reg} * {14'd0, bse_pkg::SECS_PER_HOUR};
        rem_full = prod2_reg - q_times;
        m_prod   = {13'd0, rem4_reg} * {12'd0, bse_pkg::MIN_RECIP};
        m_times  = ({6'd0, m5_reg} << 6) - ({6'd0, m5_reg} << 2);
        s_full   = rem5_reg - m_times;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (rdy[0])
                v_reg[0] <= in_valid;
            for (int k = 1; k < NSTAGE; k++)
            begin
                if (rdy[k])
                    v_reg[k] <= v_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            s_reg[0]  <= in_settings;
            prod1_reg <= {14'd0, base} * {12'd0, in_settings.shot_count};
        end
        if (rdy[1])
        begin
            s_reg[1]  <= s_reg[0];
            prod2_reg <= prod1_reg;
            q2_reg    <= q_prod[bse_pkg::HOUR_SHIFT+13:bse_pkg::HOUR_SHIFT];
        end
        if (rdy[2])
        begin
            s_reg[2] <= s_reg[1];
            q3_reg   <= q2_reg;
            rem3_reg <= rem_full[12:0];
        end
        if (rdy[3])
        begin
            s_reg[3] <= s_reg[2];
            if (rem3_reg >= {1'b0, bse_pkg::SECS_PER_HOUR})
            begin
                h4_reg   <= q3_reg + 1'b1;
                rem4_reg <= rem3_reg[11:0] - bse_pkg::SECS_PER_HOUR;
            end
            else
            begin
                h4_reg   <= q3_reg;
                rem4_reg <= rem3_reg[11:0];
            end
        end
        if (rdy[4])
        begin
            s_reg[4] <= s_reg[3];
            h5_reg   <= h4_reg;
            rem5_reg <= rem4_reg;
            m5_reg   <= m_prod[bse_pkg::MIN_SHIFT+5:bse_pkg::MIN_SHIFT];
        end
        if (rdy[5])
        begin
            s_reg[5]        <= s_reg[4];
            tot_reg.hours   <= h5_reg;
            tot_reg.minutes <= m5_reg;
            tot_reg.seconds <= s_full[5:0];
        end
    end

endmodule

// ===== rtl/button_settings_editor.sv =====
// ============================================================================
// Button settings editor
// Debounced button decode and settings editor with total duration report.
// ============================================================================
// The sample channel carries one beat per reading of the five button lines,
// stamped with a free-running millisecond time. Every accepted sample beat
// produces exactly one beat on the result channel, in order, carrying all
// settings after the sample was applied and the total shooting time.
// A new beat is accepted every cycle while the result channel is not stalled.
// The result of a sample passes the input register, the edit stage's result
// register and the duration pipeline stages (multiply, reciprocal quotient,
// remainder, correction, minutes) before the pipeline's output register
// holds the beat. The pipeline stages each hold one beat, so throughput is
// one beat per cycle while the receiver does not stall, set by the settings
// update that the edit stage applies to each beat as it advances.
// When the receiver stalls, beats pile up stage by stage and sample ready
// falls only once every stage is full, so nothing is lost or repeated.
// Reset clears all beats in flight and loads the default settings: saving
// on, lapse of thirty seconds, two hundred shots, hold-off of 250 ms and
// active-low buttons. The configuration port is a plain write port that the
// user writes only while no beat is in flight; the block does not enforce it.
// ============================================================================
module button_settings_editor (
    input  logic                           clk,
    input  logic                           rst_n,
    bse_sample_if.sink                     sample,
    bse_result_if.source                   result,
    input  logic                           cfg_we,
    input  logic [bse_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bse_pkg::CFG_DATA_W-1:0] cfg_data
);

    // Handshake between the edit stage and the duration pipeline.
    logic               edit_valid;
    logic               edit_ready;
    bse_pkg::settings_t edit_settings;

    bse_pkg::settings_t res_settings;
    bse_pkg::total_t    res_total;

    // Edit stage: hold-off window, pattern decode and settings registers.
    bse_edit u_edit (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (sample.valid),
        .in_ready     (sample.ready),
        .in_time      (sample.time_ms),
        .in_raw       (sample.raw_buttons),
        .out_valid    (edit_valid),
        .out_ready    (edit_ready),
        .out_settings (edit_settings)
    );

    // Duration pipeline: lapse seconds times shot count, split into h/m/s.
    bse_duration u_duration (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (edit_valid),
        .in_ready     (edit_ready),
        .in_settings  (edit_settings),
        .out_valid    (result.valid),
        .out_ready    (result.ready),
        .out_settings (res_settings),
        .out_total    (res_total)
    );

    // The output register of the duration pipeline drives the result beat.
    assign result.updated       = res_settings.updated;
    assign result.field_sel     = res_settings.field_sel;
    assign result.saving_on     = res_settings.saving_on;
    assign result.shooting_on   = res_settings.shooting_on;
    assign result.delay_hours   = res_settings.delay_hours;
    assign result.delay_minutes = res_settings.delay_minutes;
    assign result.lapse_minutes = res_settings.lapse_minutes;
    assign result.lapse_seconds = res_settings.lapse_seconds;
    assign result.shot_count    = res_settings.shot_count;
    assign result.total_hours   = res_total.hours;
    assign result.total_minutes = res_total.minutes;
    assign result.total_seconds = res_total.seconds;

endmodule
